>>> src/uart_rx_tx_ring_buffers_macros.svh
// Assertion macros for the UART ring buffer block.
`ifndef UART_RX_TX_RING_BUFFERS_MACROS_SVH
`define UART_RX_TX_RING_BUFFERS_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define URB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds.
`define URB_NEVER(label, cond, msg) \
  `URB_ASSERT(label, !(cond), msg)

`endif

>>> src/urb_pkg.sv
// Shared types and codes for the UART ring buffer block.
package urb_pkg;

  typedef enum logic [2:0] {
    FUNC_RX_BYTE  = 3'd0,
    FUNC_SW_READ  = 3'd1,
    FUNC_SW_WRITE = 3'd2,
    FUNC_TX_READY = 3'd3,
    FUNC_TX_DONE  = 3'd4
  } func_t;

  localparam int unsigned OUT_BITS = 24;

  typedef struct packed {
    logic rd_valid;
    logic wr_ok;
    logic ln_valid;
    logic rx_nonempty;
    logic tx_irq_en;
    logic drive;
  } status_t;

endpackage

>>> src/uart_rx_tx_ring_buffers.sv
// Top level: receive and transmit byte rings held in synchronous memories.
// A beat's status and memory read are registered, then loaded into the output register.
// No new beat is taken while the ring memory read for the last one is still in flight.
// Ready drops while a read is in flight and while an unconsumed result is not being taken.
// Reset (rst_n low, synchronous) clears pointers, interrupt enable, driver enable and mode;
// ring memory contents are left as they are.
module uart_rx_tx_ring_buffers
  import urb_pkg::*;
#(
  parameter int unsigned RX_DEPTH = 32,
  parameter int unsigned TX_DEPTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic                cfg_wr_data,   // rs485_mode
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,      // byte_in[7:0]
  input  logic [2:0]          in_tuser,      // func[2:0]
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OUT_BITS-1:0] out_tdata      // read_byte[7:0], read_valid[8],
                                             // write_accepted[9], line_byte[17:10],
                                             // line_byte_valid[18], rx_nonempty[19],
                                             // tx_irq_enable[20], rs485_drive[21], zero
);

  localparam int unsigned RX_AW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
  localparam int unsigned TX_AW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
  localparam logic [RX_AW-1:0] RX_LAST = RX_AW'(RX_DEPTH - 1);
  localparam logic [TX_AW-1:0] TX_LAST = TX_AW'(TX_DEPTH - 1);

  logic [7:0] rx_mem [RX_DEPTH];
  logic [7:0] tx_mem [TX_DEPTH];

  logic [RX_AW-1:0] rx_head_r, rx_head_nxt, rx_tail_r, rx_tail_nxt, rx_hn, rx_tn;
  logic [TX_AW-1:0] tx_head_r, tx_head_nxt, tx_tail_r, tx_tail_nxt, tx_hn, tx_tn;
  logic             irq_r, irq_nxt, drive_r, drive_nxt, mode_r;
  logic             pend_r, out_tvalid_r;
  status_t          pend_st_r, st_nxt;
  logic [7:0]       rx_rdata_r, tx_rdata_r;
  logic [OUT_BITS-1:0] out_data_r;
  logic             in_acc, rx_we, rx_re, tx_we, tx_re;
  func_t            func;

  assign func      = func_t'(in_tuser);
  assign in_tready = !pend_r && (!out_tvalid_r || out_tready);
  assign in_acc    = in_tvalid && in_tready;

  assign rx_hn = (rx_head_r == RX_LAST) ? '0 : rx_head_r + 1'b1;
  assign rx_tn = (rx_tail_r == RX_LAST) ? '0 : rx_tail_r + 1'b1;
  assign tx_hn = (tx_head_r == TX_LAST) ? '0 : tx_head_r + 1'b1;
  assign tx_tn = (tx_tail_r == TX_LAST) ? '0 : tx_tail_r + 1'b1;

  always_comb begin
    rx_head_nxt = rx_head_r;
    rx_tail_nxt = rx_tail_r;
    tx_head_nxt = tx_head_r;
    tx_tail_nxt = tx_tail_r;
    irq_nxt     = irq_r;
    drive_nxt   = drive_r;
    rx_we = 1'b0;
    rx_re = 1'b0;
    tx_we = 1'b0;
    tx_re = 1'b0;
    st_nxt = '0;
    unique case (func)
      FUNC_RX_BYTE: begin
        rx_head_nxt = rx_hn;
        rx_we       = in_acc;
      end
      FUNC_SW_READ: begin
        if (rx_head_r != rx_tail_r) begin
          rx_tail_nxt     = rx_tn;
          rx_re           = in_acc;
          st_nxt.rd_valid = 1'b1;
        end
      end
      FUNC_SW_WRITE: begin
        if (tx_hn != tx_tail_r) begin
          tx_head_nxt  = tx_hn;
          tx_we        = in_acc;
          irq_nxt      = 1'b1;
          st_nxt.wr_ok = 1'b1;
        end
      end
      FUNC_TX_READY: begin
        if (tx_head_r != tx_tail_r) begin
          if (mode_r) begin
            drive_nxt = 1'b1;
          end
          tx_tail_nxt     = tx_tn;
          tx_re           = in_acc;
          st_nxt.ln_valid = 1'b1;
        end else begin
          irq_nxt = 1'b0;
        end
      end
      FUNC_TX_DONE: begin
        drive_nxt = 1'b0;
      end
      default: begin
      end
    endcase
    st_nxt.rx_nonempty = (rx_head_nxt != rx_tail_nxt);
    st_nxt.tx_irq_en   = irq_nxt;
    st_nxt.drive       = drive_nxt;
  end

  always_ff @(posedge clk) begin
    if (rx_we) begin
      rx_mem[rx_hn] <= in_tdata;
    end
    if (rx_re) begin
      rx_rdata_r <= rx_mem[rx_tn];
    end
    if (tx_we) begin
      tx_mem[tx_hn] <= in_tdata;
    end
    if (tx_re) begin
      tx_rdata_r <= tx_mem[tx_tn];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_head_r    <= '0;
      rx_tail_r    <= '0;
      tx_head_r    <= '0;
      tx_tail_r    <= '0;
      irq_r        <= 1'b0;
      drive_r      <= 1'b0;
      mode_r       <= 1'b0;
      pend_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        mode_r <= cfg_wr_data;
      end
      if (in_acc) begin
        rx_head_r <= rx_head_nxt;
        rx_tail_r <= rx_tail_nxt;
        tx_head_r <= tx_head_nxt;
        tx_tail_r <= tx_tail_nxt;
        irq_r     <= irq_nxt;
        drive_r   <= drive_nxt;
      end
      pend_r <= in_acc;
      if (pend_r) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      pend_st_r <= st_nxt;
    end
    if (pend_r) begin
      out_data_r <= {2'b00, pend_st_r.drive, pend_st_r.tx_irq_en, pend_st_r.rx_nonempty,
                     pend_st_r.ln_valid, pend_st_r.ln_valid ? tx_rdata_r : 8'h00,
                     pend_st_r.wr_ok, pend_st_r.rd_valid,
                     pend_st_r.rd_valid ? rx_rdata_r : 8'h00};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

`include "uart_rx_tx_ring_buffers_macros.svh"

  `URB_ASSERT(a_pend_loads_out, pend_r |=> out_tvalid_r, "result lost after memory read")
  `URB_ASSERT(a_accept_pends, in_acc |=> pend_r, "accepted beat did not start a read")
  `URB_NEVER(a_pend_blocked, pend_r && out_tvalid_r && !out_tready,
             "read completes into an occupied output register")
  `URB_ASSERT(a_drive_mode, $rose(drive_r) |-> $past(mode_r), "driver raised with mode off")

endmodule
